// ===== rtl/cgrt_pkg.sv =====
// shared types and constants for the channel group reservation table
package cgrt_pkg;

   localparam int DEF_TABLE_ENTRIES = 256;
   localparam int CHANNEL_COUNT     = 64;

   localparam int CHANNEL_W  = 6;
   localparam int GROUP_W    = 64;
   localparam int REQ_DATA_W = ((CHANNEL_W + GROUP_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = GROUP_W;

   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_TAKE = 1'b1;

   typedef struct packed {
      logic                 valid;
      logic [CHANNEL_W-1:0] chan;
   } tag_type;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

endpackage

// ===== rtl/channel_group_reservation_table.sv =====
// channel group reservation table: ring of channel / group id entries in memory
//
// request channel (req_*): req_tuser is the command (add or take), req_tdata
// carries the channel and the group id. every request gives one response on
// rsp_*: rsp_tuser is the found flag, rsp_tdata the taken group id (0 if none).
// add stores at the write position and wraps, overwriting the oldest entry.
// take scans the table from index 0 and clears the first valid entry whose
// channel matches. a channel at or above CHANNEL_COUNT is ignored by add and
// never found by take.
// one request is in work at a time. an add goes straight to the done state,
// which registers the response. a take walks the tag memory one entry a
// cycle through its single read port until a hit or the last entry, then
// goes to the done state.
// after reset a clearing pass over every entry zeroes the valid bits;
// req_tready stays low during it.
// a response waiting on a low rsp_tready holds; the next request is still
// taken, and its result waits in a pending register until the output frees.
module channel_group_reservation_table #(
   parameter int TABLE_ENTRIES = cgrt_pkg::DEF_TABLE_ENTRIES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [cgrt_pkg::REQ_DATA_W-1:0] req_tdata,  // channel, group, zero pad
   input  logic                            req_tuser,  // cmd
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [cgrt_pkg::RSP_DATA_W-1:0] rsp_tdata,  // taken group
   output logic                            rsp_tuser   // found
);
   import cgrt_pkg::*;

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [AW-1:0] LAST_IDX   = AW'(TABLE_ENTRIES - 1);
   localparam logic [8:0]    CHAN_LIMIT = 9'(CHANNEL_COUNT);

   tag_type            tag_mem [TABLE_ENTRIES];
   logic [GROUP_W-1:0] group_mem [TABLE_ENTRIES];

   state_type          state_ff, state_in;
   logic [AW-1:0]      wp_ff, wp_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [CHANNEL_W-1:0] key_ff, key_in;
   logic               pend_found_ff, pend_found_in;
   logic [GROUP_W-1:0] pend_group_ff, pend_group_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [GROUP_W-1:0] rsp_group_ff, rsp_group_in;

   tag_type            tag_rd_ff;
   logic [GROUP_W-1:0] group_rd_ff;

   logic [CHANNEL_W-1:0] req_chan;
   logic [GROUP_W-1:0]   req_group;
   logic                 req_fire;
   logic                 chan_ok;
   logic                 out_free;
   logic                 hit;

   logic [AW-1:0]      rd_addr;
   logic               tag_we;
   logic [AW-1:0]      tag_waddr;
   tag_type            tag_wdata;
   logic               group_we;

   assign req_chan  = req_tdata[CHANNEL_W-1:0];
   assign req_group = req_tdata[CHANNEL_W+GROUP_W-1:CHANNEL_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire  = req_tvalid && req_tready;
   assign chan_ok   = ({{(9 - CHANNEL_W){1'b0}}, req_chan} < CHAN_LIMIT);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign hit       = tag_rd_ff.valid && (tag_rd_ff.chan == key_ff);

   // the scan reads one entry ahead of the one being compared
   assign rd_addr = (state_ff == ST_SCAN) ? AW'(idx_ff + 1'b1) : '0;

   always_comb begin
      state_in      = state_ff;
      wp_in         = wp_ff;
      idx_in        = idx_ff;
      key_in        = key_ff;
      pend_found_in = pend_found_ff;
      pend_group_in = pend_group_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_found_in  = rsp_found_ff;
      rsp_group_in  = rsp_group_ff;
      tag_we        = 1'b0;
      tag_waddr     = idx_ff;
      tag_wdata     = '0;
      group_we      = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            tag_we    = 1'b1;
            tag_waddr = idx_ff;
            idx_in    = AW'(idx_ff + 1'b1);
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               pend_found_in = 1'b0;
               pend_group_in = '0;
               key_in        = req_chan;
               idx_in        = '0;
               state_in      = ST_DONE;
               if (req_tuser == CMD_ADD) begin
                  if (chan_ok) begin
                     tag_we          = 1'b1;
                     tag_waddr       = wp_ff;
                     tag_wdata.valid = 1'b1;
                     tag_wdata.chan  = req_chan;
                     group_we        = 1'b1;
                     wp_in = (wp_ff == LAST_IDX) ? '0 : AW'(wp_ff + 1'b1);
                  end
               end else if (chan_ok) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               tag_we        = 1'b1;
               tag_waddr     = idx_ff;
               pend_found_in = 1'b1;
               pend_group_in = group_rd_ff;
               state_in      = ST_DONE;
            end else if (idx_ff == LAST_IDX) begin
               state_in = ST_DONE;
            end else begin
               idx_in = AW'(idx_ff + 1'b1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = pend_found_ff;
               rsp_group_in = pend_group_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            idx_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         wp_ff        <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      pend_found_ff <= pend_found_in;
      pend_group_ff <= pend_group_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_group_ff  <= rsp_group_in;
   end

   // tag memory: valid bit and channel
   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[tag_waddr] <= tag_wdata;
      end
      tag_rd_ff <= tag_mem[rd_addr];
   end

   // group memory, written by add only
   always_ff @(posedge clock) begin
      if (group_we) begin
         group_mem[wp_ff] <= req_group;
      end
      group_rd_ff <= group_mem[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = rsp_group_ff;

endmodule

// ===== rtl/cgrt_checker.sv =====
// port-level checker for the channel group reservation table, with its bind
module cgrt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [cgrt_pkg::REQ_DATA_W-1:0] req_tdata,  // channel, group, zero pad
   input logic                            req_tuser,  // cmd
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [cgrt_pkg::RSP_DATA_W-1:0] rsp_tdata,  // taken group
   input logic                            rsp_tuser   // found
);
   import cgrt_pkg::*;

   logic [REQ_DATA_W-1:0] req_seen;
   assign req_seen = req_tdata ^ {REQ_DATA_W{req_tuser}};

   // a miss or an add always reports group id zero
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("response without hit carries a nonzero group id");

   // the clearing pass keeps requests out right after reset
   a_clear_pass: assert property (@(posedge clock)
      $fell(reset) |-> !req_tready)
      else $error("request accepted during the clearing pass");

   // one request at a time
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in work");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // request payload is watched for x on accept
   a_req_known: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !$isunknown(req_seen))
      else $error("request accepted with unknown payload");

endmodule

bind channel_group_reservation_table cgrt_checker u_cgrt_checker (.*);
